// File: hdl/button_gesture_classifier_top_assert.svh
// assertion macros shared by the button gesture classifier modules
`ifndef BUTTON_GESTURE_CLASSIFIER_TOP_ASSERT_SVH
`define BUTTON_GESTURE_CLASSIFIER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BGC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bgc check failed");

// next-cycle implication, checked outside reset
`define BGC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bgc check failed");

`endif

// File: hdl/bgc_pkg.sv
// types and constants of the button gesture classifier
package bgc_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned IDX_W    = 8;
    localparam int unsigned CLICK_W  = 2;

    localparam logic [CLICK_W-1:0] CLICK_MAX = 2'd3;

    // register indices of the configuration port
    localparam logic [IDX_W-1:0] REG_DEBOUNCE   = 8'd0;
    localparam logic [IDX_W-1:0] REG_LONG_PRESS = 8'd1;
    localparam logic [IDX_W-1:0] REG_GAP_ONE    = 8'd2;
    localparam logic [IDX_W-1:0] REG_GAP_MORE   = 8'd3;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] RST_DEBOUNCE   = 16'd30;
    localparam logic [CFG_W-1:0] RST_LONG_PRESS = 16'd600;
    localparam logic [CFG_W-1:0] RST_GAP_ONE    = 16'd250;
    localparam logic [CFG_W-1:0] RST_GAP_MORE   = 16'd250;

    // pin level codes, low means pressed
    localparam logic LEVEL_PRESSED  = 1'b0;
    localparam logic LEVEL_RELEASED = 1'b1;

    typedef enum logic [2:0] {
        G_NONE   = 3'd0,
        G_SINGLE = 3'd1,
        G_DOUBLE = 3'd2,
        G_TRIPLE = 3'd3,
        G_LONG   = 3'd4
    } t_gesture;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] long_press_time;
        logic [CFG_W-1:0] gap_after_one;
        logic [CFG_W-1:0] gap_after_more;
    } t_cfg;

endpackage

// File: hdl/bgc_cfg_regs.sv
// configuration register file of the button gesture classifier
module bgc_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [bgc_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [bgc_pkg::CFG_W-1:0]  i_cfg_data,
    output logic                       o_cfg_ready,
    output bgc_pkg::t_cfg              o_cfg
);
    import bgc_pkg::*;

    t_cfg r_cfg;

    // writes are always taken
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register write, unknown indices ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time   <= RST_DEBOUNCE;
            r_cfg.long_press_time <= RST_LONG_PRESS;
            r_cfg.gap_after_one   <= RST_GAP_ONE;
            r_cfg.gap_after_more  <= RST_GAP_MORE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DEBOUNCE:   r_cfg.debounce_time   <= i_cfg_data;
                REG_LONG_PRESS: r_cfg.long_press_time <= i_cfg_data;
                REG_GAP_ONE:    r_cfg.gap_after_one   <= i_cfg_data;
                REG_GAP_MORE:   r_cfg.gap_after_more  <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// File: hdl/bgc_classifier.sv
// debounce, click counting and long press state with its one-poll update
module bgc_classifier (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_level,
    input  logic [bgc_pkg::TIME_W-1:0]  i_now,
    input  bgc_pkg::t_cfg               i_cfg,
    output bgc_pkg::t_gesture           o_gesture
);
    import bgc_pkg::*;

    `include "button_gesture_classifier_top_assert.svh"

    logic               r_stable_level;
    logic [TIME_W-1:0]  r_change_time;
    logic               r_is_held;
    logic [TIME_W-1:0]  r_hold_start;
    logic               r_long_done;
    logic [CLICK_W-1:0] r_click_total;

    logic               n_stable_level;
    logic [TIME_W-1:0]  n_change_time;
    logic               n_is_held;
    logic [TIME_W-1:0]  n_hold_start;
    logic               n_long_done;
    logic [CLICK_W-1:0] n_click_total;
    t_gesture           n_gesture;

    logic [TIME_W-1:0]  since_change;
    logic [TIME_W-1:0]  since_hold;
    logic [TIME_W-1:0]  eff_change;
    logic [TIME_W-1:0]  eff_hold;
    logic [CFG_W-1:0]   gap;
    logic               take_edge;

    // elapsed times against the stored marks, wrapping
    assign since_change = i_now - r_change_time;
    assign since_hold   = i_now - r_hold_start;
    assign take_edge    = (i_level != r_stable_level) &&
                          (since_change >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.debounce_time});

    // one poll: debounce, then long press, then click decision
    always_comb begin
        n_stable_level = r_stable_level;
        n_change_time  = r_change_time;
        n_is_held      = r_is_held;
        n_hold_start   = r_hold_start;
        n_long_done    = r_long_done;
        n_click_total  = r_click_total;
        n_gesture      = G_NONE;
        eff_change     = since_change;
        eff_hold       = since_hold;

        if (take_edge) begin
            n_stable_level = i_level;
            n_change_time  = i_now;
            eff_change     = '0;
            if (i_level == LEVEL_PRESSED) begin
                n_is_held    = 1'b1;
                n_hold_start = i_now;
                n_long_done  = 1'b0;
                eff_hold     = '0;
            end else begin
                n_is_held = 1'b0;
                if (!r_long_done && (r_click_total != CLICK_MAX)) begin
                    n_click_total = r_click_total + 1'b1;
                end
            end
        end

        gap = (n_click_total == 2'd1) ? i_cfg.gap_after_one : i_cfg.gap_after_more;

        if (n_is_held && !n_long_done &&
            (eff_hold >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.long_press_time})) begin
            n_long_done   = 1'b1;
            n_click_total = '0;
            n_gesture     = G_LONG;
        end else if (!n_is_held && (n_click_total != '0) &&
                     (eff_change >= {{(TIME_W-CFG_W){1'b0}}, gap})) begin
            case (n_click_total)
                2'd1:    n_gesture = G_SINGLE;
                2'd2:    n_gesture = G_DOUBLE;
                default: n_gesture = G_TRIPLE;
            endcase
            n_click_total = '0;
        end
    end

    assign o_gesture = n_gesture;

    // state update once per poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_level <= LEVEL_RELEASED;
            r_change_time  <= '0;
            r_is_held      <= 1'b0;
            r_hold_start   <= '0;
            r_long_done    <= 1'b0;
            r_click_total  <= '0;
        end else if (i_en) begin
            r_stable_level <= n_stable_level;
            r_change_time  <= n_change_time;
            r_is_held      <= n_is_held;
            r_hold_start   <= n_hold_start;
            r_long_done    <= n_long_done;
            r_click_total  <= n_click_total;
        end
    end

    `BGC_ASSERT_IMP(a_held_matches_level, i_clk, i_rst_n, 1'b1, r_is_held != r_stable_level)
    `BGC_ASSERT_NXT(a_long_marks_done, i_clk, i_rst_n, i_en && (n_gesture == G_LONG),
        r_long_done && r_is_held)
    `BGC_ASSERT_NXT(a_gesture_clears_clicks, i_clk, i_rst_n, i_en && (n_gesture != G_NONE),
        r_click_total == '0)

endmodule

// File: hdl/button_gesture_classifier_top.sv
// top level of the button gesture classifier
// Classifies polls of a button into single, double, triple click and long press.
// Poll channel (i_s_*): one transaction per poll, tdata holds the raw pin level
// (low means pressed) and a free-running millisecond timestamp.
// Result channel (o_m_*): exactly one transaction per poll, in order, carrying the
// gesture code (0 none, 1 single, 2 double, 3 triple, 4 long press).
// Configuration channel (i_cfg_*): register index and 16-bit value, always ready;
// write only while no poll is in flight.
// Data path: the poll is held in the input register, then its result in the
// result register; the classifier update sits between the two.
// Throughput: one poll per cycle while the receiver takes results.
// When the receiver stalls, the result register holds its item and the input
// register takes one more poll only if it is empty; further polls wait on o_s_tready.
// Reset clears the valid flags of both pipeline registers, loads default timings
// and treats the button as released at time 0.
module button_gesture_classifier_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [0] raw_level, [32:1] now_ms, [39:33] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [2:0] gesture, [7:3] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import bgc_pkg::*;

    `include "button_gesture_classifier_top_assert.svh"

    t_cfg              cfg;
    t_gesture          gesture;
    logic              advance;
    logic              step_en;

    logic              r_in_valid;
    logic              r_in_level;
    logic [TIME_W-1:0] r_in_now;
    logic              r_out_valid;
    t_gesture          r_out_gesture;

    bgc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    // pipeline moves when the result register is free or being drained
    assign advance    = !r_out_valid || i_m_tready;
    assign step_en    = advance && r_in_valid;
    assign o_s_tready = !r_in_valid || advance;

    bgc_classifier u_cls (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (step_en),
        .i_level   (r_in_level),
        .i_now     (r_in_now),
        .i_cfg     (cfg),
        .o_gesture (gesture)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_level <= i_s_tdata[0];
            r_in_now   <= i_s_tdata[TIME_W:1];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_en) begin
            r_out_gesture <= gesture;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_gesture};

    `BGC_ASSERT_IMP(a_full_blocks_input, i_clk, i_rst_n,
        r_in_valid && r_out_valid && !i_m_tready, !o_s_tready)
    `BGC_ASSERT_NXT(a_step_fills_output, i_clk, i_rst_n, step_en, r_out_valid)
    `BGC_ASSERT_NXT(a_stalled_result_holds, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata))

endmodule
